### rtl/core/mep_pkg.sv
// Package for the Mandelbrot escape-time pixel unit.
// Holds field widths, register indexes and reset values, and the controller types.
// No dependencies.
package mep_pkg;

    localparam int ROW_W      = 12;
    localparam int COL_W      = 13;
    localparam int COUNT_W    = 16;
    localparam int GREY_W     = 8;
    localparam int Q_W        = 32;
    localparam int STEP_W     = 28;
    localparam int FRAC_BITS  = 27;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int SQ_W       = 36;
    localparam int CLAMP_W    = 17;

    localparam int MAX_COLUMNS_DEF = 8192;
    localparam int MAX_ROWS_DEF    = 4096;

    localparam logic [CFG_IDX_W-1:0] REG_LEFT_EDGE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_EDGE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_X     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_Y     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT = 3'd4;

    localparam logic signed [Q_W-1:0] LEFT_EDGE_RST  = -32'sd369098752;
    localparam logic signed [Q_W-1:0] TOP_EDGE_RST   = 32'sd134217728;
    localparam logic [STEP_W-1:0]     STEP_X_RST     = 28'd67117;
    localparam logic [STEP_W-1:0]     STEP_Y_RST     = 28'd67125;
    localparam logic [COUNT_W-1:0]    ITER_LIMIT_RST = 16'd255;

    localparam logic [GREY_W-1:0]  GREY_FULL = 8'hFF;
    localparam logic [SQ_W:0]      MAG_LIMIT = 37'h0_2000_0000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMUL,
        S_CADD,
        S_UPD,
        S_MUL,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load_pix;
        logic calc_c;
        logic load_c;
        logic step;
        logic mult;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic cont;
        logic out_free;
    } t_dp_sts;

endpackage

### rtl/core/mep_if.sv
// Channel interfaces for the Mandelbrot escape-time pixel unit.
// Depends on mep_pkg for field widths.
interface mep_pix_if;
    import mep_pkg::*;
    logic             valid;
    logic             ready;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    modport source (output valid, output row, output col, input ready);
    modport sink   (input valid, input row, input col, output ready);
endinterface

interface mep_res_if;
    import mep_pkg::*;
    logic               valid;
    logic               ready;
    logic [ROW_W-1:0]   out_row;
    logic [COL_W-1:0]   out_col;
    logic [COUNT_W-1:0] escape_count;
    logic [GREY_W-1:0]  grey_level;
    modport source (output valid, output out_row, output out_col, output escape_count,
                    output grey_level, input ready);
    modport sink   (input valid, input out_row, input out_col, input escape_count,
                    input grey_level, output ready);
endinterface

interface mep_cfg_if;
    import mep_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/mep_ctrl.sv
// Controller state machine of the Mandelbrot escape-time pixel unit.
// Sequences set-up, iteration and result hand-off; depends on mep_pkg.
module mep_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_pix_valid,
    output logic             o_pix_ready,
    input  mep_pkg::t_dp_sts i_sts,
    output mep_pkg::t_dp_cmd o_cmd
);
    import mep_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_pix_valid) begin
                    n_state = S_CMUL;
                end
            end
            S_CMUL: n_state = S_CADD;
            S_CADD: n_state = S_UPD;
            S_UPD: begin
                n_state = i_sts.cont ? S_MUL : S_DONE;
            end
            S_MUL: n_state = S_UPD;
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_pix_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_pix_ready    = 1'b1;
                o_cmd.load_pix = i_pix_valid;
            end
            S_CMUL: o_cmd.calc_c = 1'b1;
            S_CADD: o_cmd.load_c = 1'b1;
            S_UPD:  o_cmd.step   = i_sts.cont;
            S_MUL:  o_cmd.mult   = 1'b1;
            S_DONE: o_cmd.load_out = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

### rtl/core/mep_dp.sv
// Datapath of the Mandelbrot escape-time pixel unit: configuration registers,
// point set-up, the z update with its three multipliers, and the result register.
// Depends on mep_pkg.
module mep_dp #(
    parameter int MAX_COLUMNS = mep_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = mep_pkg::MAX_ROWS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mep_pkg::t_dp_cmd                  i_cmd,
    output mep_pkg::t_dp_sts                  o_sts,
    input  logic [mep_pkg::ROW_W-1:0]         i_row,
    input  logic [mep_pkg::COL_W-1:0]         i_col,
    input  logic                              i_cfg_valid,
    input  logic [mep_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mep_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                              o_res_valid,
    input  logic                              i_res_ready,
    output logic [mep_pkg::ROW_W-1:0]         o_out_row,
    output logic [mep_pkg::COL_W-1:0]         o_out_col,
    output logic [mep_pkg::COUNT_W-1:0]       o_escape_count,
    output logic [mep_pkg::GREY_W-1:0]        o_grey_level
);
    import mep_pkg::*;

    localparam logic [CLAMP_W-1:0] COL_LAST = CLAMP_W'(MAX_COLUMNS - 1);
    localparam logic [CLAMP_W-1:0] ROW_LAST = CLAMP_W'(MAX_ROWS - 1);
    localparam int PX_W = COL_W + STEP_W;
    localparam int PY_W = ROW_W + STEP_W;
    localparam int SUM_W = PX_W + 2;

    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-Q_W:0] top;
        top = v[SUM_W-1:Q_W-1];
        if ((top == '0) || (top == '1)) begin
            sat_q = v[Q_W-1:0];
        end else if (v[SUM_W-1]) begin
            sat_q = {1'b1, {(Q_W-1){1'b0}}};
        end else begin
            sat_q = {1'b0, {(Q_W-1){1'b1}}};
        end
    endfunction

    logic signed [Q_W-1:0]    r_left;
    logic signed [Q_W-1:0]    r_top;
    logic [STEP_W-1:0]        r_step_x;
    logic [STEP_W-1:0]        r_step_y;
    logic [COUNT_W-1:0]       r_limit;

    logic [ROW_W-1:0]         r_row;
    logic [COL_W-1:0]         r_col;
    logic [PX_W-1:0]          r_prod_x;
    logic [PY_W-1:0]          r_prod_y;
    logic signed [Q_W-1:0]    r_c_re;
    logic signed [Q_W-1:0]    r_c_im;
    logic signed [Q_W-1:0]    r_zr;
    logic signed [Q_W-1:0]    r_zi;
    logic [SQ_W-1:0]          r_zr2;
    logic [SQ_W-1:0]          r_zi2;
    logic [Q_W-1:0]           r_zrzi;
    logic [COUNT_W-1:0]       r_k;

    logic                     r_out_valid;
    logic [ROW_W-1:0]         r_o_row;
    logic [COL_W-1:0]         r_o_col;
    logic [COUNT_W-1:0]       r_o_count;
    logic [GREY_W-1:0]        r_o_grey;

    logic [COL_W-1:0]         w_col_c;
    logic [ROW_W-1:0]         w_row_c;
    logic signed [SUM_W-1:0]  w_sum_re;
    logic signed [SUM_W-1:0]  w_sum_im;
    logic signed [2*Q_W-1:0]  w_p_rr;
    logic signed [2*Q_W-1:0]  w_p_ii;
    logic signed [2*Q_W-1:0]  w_p_ri;
    logic signed [2*Q_W-1:0]  w_s_rr;
    logic signed [2*Q_W-1:0]  w_s_ii;
    logic signed [2*Q_W-1:0]  w_s_ri;
    logic [Q_W-1:0]           n_zr;
    logic [Q_W-1:0]           n_zi;
    logic [SQ_W:0]            w_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= LEFT_EDGE_RST;
            r_top    <= TOP_EDGE_RST;
            r_step_x <= STEP_X_RST;
            r_step_y <= STEP_Y_RST;
            r_limit  <= ITER_LIMIT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_LEFT_EDGE:  r_left   <= i_cfg_data;
                REG_TOP_EDGE:   r_top    <= i_cfg_data;
                REG_STEP_X:     r_step_x <= i_cfg_data[STEP_W-1:0];
                REG_STEP_Y:     r_step_y <= i_cfg_data[STEP_W-1:0];
                REG_ITER_LIMIT: r_limit  <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_col_c = ({{(CLAMP_W-COL_W){1'b0}}, r_col} > COL_LAST) ?
                     COL_LAST[COL_W-1:0] : r_col;
    assign w_row_c = ({{(CLAMP_W-ROW_W){1'b0}}, r_row} > ROW_LAST) ?
                     ROW_LAST[ROW_W-1:0] : r_row;

    assign w_sum_re = SUM_W'(r_left) + $signed({{(SUM_W-PX_W){1'b0}}, r_prod_x});
    assign w_sum_im = SUM_W'(r_top) - $signed({{(SUM_W-PY_W){1'b0}}, r_prod_y});

    assign w_p_rr = r_zr * r_zr;
    assign w_p_ii = r_zi * r_zi;
    assign w_p_ri = r_zr * r_zi;
    assign w_s_rr = w_p_rr >>> FRAC_BITS;
    assign w_s_ii = w_p_ii >>> FRAC_BITS;
    assign w_s_ri = w_p_ri >>> FRAC_BITS;

    assign n_zi  = {r_zrzi[Q_W-2:0], 1'b0} + r_c_im;
    assign n_zr  = r_zr2[Q_W-1:0] - r_zi2[Q_W-1:0] + r_c_re;
    assign w_mag = {1'b0, r_zr2} + {1'b0, r_zi2};

    assign o_sts.cont     = (r_k < r_limit) && (w_mag < MAG_LIMIT);
    assign o_sts.out_free = !r_out_valid || i_res_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_pix) begin
            r_row <= i_row;
            r_col <= i_col;
        end
        if (i_cmd.calc_c) begin
            r_prod_x <= PX_W'(w_col_c) * PX_W'(r_step_x);
            r_prod_y <= PY_W'(w_row_c) * PY_W'(r_step_y);
        end
        if (i_cmd.load_c) begin
            r_c_re <= sat_q(w_sum_re);
            r_c_im <= sat_q(w_sum_im);
            r_zr2  <= '0;
            r_zi2  <= '0;
            r_zrzi <= '0;
            r_k    <= '0;
        end
        if (i_cmd.step) begin
            r_zr <= n_zr;
            r_zi <= n_zi;
            r_k  <= r_k + 1'b1;
        end
        if (i_cmd.mult) begin
            r_zr2  <= w_s_rr[SQ_W-1:0];
            r_zi2  <= w_s_ii[SQ_W-1:0];
            r_zrzi <= w_s_ri[Q_W-1:0];
        end
        if (i_cmd.load_out) begin
            r_o_row   <= r_row;
            r_o_col   <= r_col;
            r_o_count <= r_k;
            r_o_grey  <= (r_k != r_limit) ? r_k[GREY_W-1:0] : GREY_FULL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_res_valid    = r_out_valid;
    assign o_out_row      = r_o_row;
    assign o_out_col      = r_o_col;
    assign o_escape_count = r_o_count;
    assign o_grey_level   = r_o_grey;

endmodule

### rtl/core/mandelbrot_escape_time_pixel_unit.sv
// Top level of the Mandelbrot escape-time pixel unit.
// Joins mep_ctrl and mep_dp; depends on mep_pkg and the interfaces in mep_if.
//
//  Channel   Dir   Contents                                            Transaction
//  i_pix     in    row, col                                            valid & ready
//  o_res     out   out_row, out_col, escape_count, grey_level          valid & ready
//  i_cfg     in    index, data (register write)                        valid & ready
//
// After its transaction a pixel passes through S_CMUL and S_CADD, which set up c, then through
// S_UPD and S_MUL once per iteration; S_DONE registers the result once the output is free.
// One pixel is worked on at a time; the next is taken once the result is registered.
// Reset is synchronous and active low and loads the register defaults.
// A stalled result holds in the output register while the next pixel is accepted.
// Configuration writes are always accepted and take effect in the next cycle.
module mandelbrot_escape_time_pixel_unit #(
    parameter int MAX_COLUMNS = mep_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = mep_pkg::MAX_ROWS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    mep_pix_if.sink        i_pix,
    mep_res_if.source      o_res,
    mep_cfg_if.sink        i_cfg
);
    import mep_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_pix_ready;

    mep_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix_valid (i_pix.valid),
        .o_pix_ready (w_pix_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    mep_dp #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_row          (i_pix.row),
        .i_col          (i_pix.col),
        .i_cfg_valid    (i_cfg.valid),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .o_res_valid    (o_res.valid),
        .i_res_ready    (o_res.ready),
        .o_out_row      (o_res.out_row),
        .o_out_col      (o_res.out_col),
        .o_escape_count (o_res.escape_count),
        .o_grey_level   (o_res.grey_level)
    );

    assign i_pix.ready = w_pix_ready;
    assign i_cfg.ready = 1'b1;

endmodule

### rtl/core/mep_checker.sv
// Port-level checks for the Mandelbrot escape-time pixel unit, bound to its top level.
// Depends on mep_pkg for field widths.
module mep_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_pix_valid,
    input logic                         i_pix_ready,
    input logic                         i_res_valid,
    input logic                         i_res_ready,
    input logic [mep_pkg::COUNT_W-1:0]  i_escape_count,
    input logic [mep_pkg::GREY_W-1:0]   i_grey_level
);
    import mep_pkg::*;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix_valid && i_pix_ready) |=> !i_pix_ready)
        else $error("input still ready right after a pixel transaction");

    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_res_valid) |-> $past(!i_pix_ready))
        else $error("result appeared while no pixel was in work");

    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid right after reset");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=>
            (i_res_valid && $stable(i_escape_count) && $stable(i_grey_level)))
        else $error("stalled result changed");

endmodule

bind mandelbrot_escape_time_pixel_unit mep_checker u_mep_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_pix_valid    (i_pix.valid),
    .i_pix_ready    (i_pix.ready),
    .i_res_valid    (o_res.valid),
    .i_res_ready    (o_res.ready),
    .i_escape_count (o_res.escape_count),
    .i_grey_level   (o_res.grey_level)
);
